@@ hdl/gra_pkg.sv @@
package gra_pkg;

    localparam int DEF_MAX_COLS = 16;
    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_TAGS = 255;

    localparam int COLS_RESET = 10;
    localparam int ROWS_RESET = 4;

    localparam int ADDR_W = 3;
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    localparam logic [2:0] CMD_PLACE    = 3'd0;
    localparam logic [2:0] CMD_LOOKUP   = 3'd1;
    localparam logic [2:0] CMD_REMOVE   = 3'd2;
    localparam logic [2:0] CMD_FIT      = 3'd3;
    localparam logic [2:0] CMD_CONTAINS = 3'd4;

    localparam logic [8:0] USED_MAX = 9'd256;

endpackage

@@ hdl/grid_rectangle_allocator.sv @@
// grid rectangle allocator: an occupancy grid of owner tags (0 = empty) held in a
// single-port-write / single-port-read ram, plus a ram of recorded sizes per tag.
// after reset the block sweeps the whole grid to zero, one cell per cycle, and
// takes no item meanwhile; register writes are taken at any time. each item is
// then worked by one small sequencer around the grid ram read port: every cell
// checked is addressed (ST_RD) and then its registered data checked (ST_CHK),
// every cell written is written in ST_WR, and ST_DONE moves the result to the
// output register. lookup reads one cell, place stops at the first occupied
// cell, contains scans the grid up to the first cell holding the tag, remove
// finds the anchor of the tag and then clears its cells, and a fit query checks
// cells over all candidate positions, stopping at the first occupied cell of
// each candidate. rejected or unknown commands go straight to the result.
// one item is in work at a time; a finished result waits in the output register
// while the next item is accepted.
module grid_rectangle_allocator #(
    parameter int MAX_COLS = gra_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gra_pkg::DEF_MAX_ROWS,
    parameter int MAX_TAGS = gra_pkg::DEF_MAX_TAGS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // apb-style configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gra_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // command channel
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  logic [2:0]                 cmd,
    input  logic [3:0]                 col,
    input  logic [3:0]                 row,
    input  logic [4:0]                 rect_width,
    input  logic [4:0]                 rect_height,
    input  logic [7:0]                 owner_tag,
    // result channel
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic                       ok,
    output logic [7:0]                 tag_out,
    output logic [8:0]                 used_cells
);
    import gra_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int TDEP  = MAX_TAGS + 1;
    localparam int TAW   = $clog2(TDEP > 1 ? TDEP : 2);
    localparam int MAXD  = MAX_COLS > MAX_ROWS ? MAX_COLS : MAX_ROWS;
    // coordinates plus a rectangle extent and one step beyond
    localparam int DW    = $clog2(MAXD + 34);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_CHK, ST_WR, ST_TSZ_RD, ST_TSZ_USE, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_PLACE, PH_LOOKUP, PH_RMCELL, PH_RMFIND, PH_FIT, PH_CONT
    } phase_t;

    state_t         state_reg, state_next;
    phase_t         phase_reg, phase_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [DW-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic [DW-1:0]  bx_reg, bx_next, by_reg, by_next;
    logic [DW-1:0]  ex_reg, ex_next, ey_reg, ey_next;
    logic [4:0]     w_reg, w_next, h_reg, h_next;
    logic [7:0]     tag_reg, tag_next;
    logic [DW-1:0]  cols_reg, cols_next, rows_reg, rows_next;
    logic [8:0]     used_reg, used_next;
    logic           res_ok_reg, res_ok_next;
    logic [7:0]     res_tag_reg, res_tag_next;
    logic           ok_reg, ok_next;
    logic [7:0]     tag_out_reg, tag_out_next;
    logic [8:0]     used_out_reg, used_out_next;
    logic           rsp_valid_reg, rsp_valid_next;

    // grid ram
    logic           g_we;
    logic [AW-1:0]  g_waddr, g_addr;
    logic [7:0]     g_wdata, g_rdata;
    // tag size ram: {width, height}
    logic           s_we;
    logic [TAW-1:0] s_addr;
    logic [9:0]     s_rdata;

    gra_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_grid (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_addr),
        .rdata (g_rdata)
    );

    gra_ram #(.WIDTH(10), .DEPTH(TDEP)) u_size (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_addr),
        .wdata ({w_reg, h_reg}),
        .raddr (s_addr),
        .rdata (s_rdata)
    );

    logic           wr_cfg;
    logic [DW-1:0]  cfg_val, cfg_cols, cfg_rows;
    logic [DW-1:0]  c_in, r_in, w_in, h_in;
    logic           scan_last;
    logic [DW-1:0]  adv_x, adv_y;
    logic [9:0]     area;
    logic [9:0]     rm_area;
    logic [10:0]    used_sum;
    logic [DW-1:0]  sw, sh, end_x, end_y;
    logic [DW-1:0]  nbx, nby;
    logic           tag_legal;

    assign g_addr  = AW'(int'(cy_reg) * MAX_COLS + int'(cx_reg));
    assign g_waddr = (state_reg == ST_CLEAR) ? clr_reg : g_addr;
    assign g_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WR);
    assign g_wdata = (state_reg == ST_WR && phase_reg == PH_PLACE) ? tag_reg : 8'd0;
    assign s_addr  = TAW'(tag_reg);
    assign s_we    = (state_reg == ST_WR) && (phase_reg == PH_PLACE) && scan_last;

    assign pready    = 1'b1;
    assign prdata    = paddr[2] == REG_COLS ? 32'(cols_reg) : 32'(rows_reg);
    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign ok        = ok_reg;
    assign tag_out   = tag_out_reg;
    assign used_cells = used_out_reg;

    assign wr_cfg   = psel && penable && pwrite;
    assign cfg_val  = DW'(pwdata[4:0]);
    assign cfg_cols = (cfg_val == '0) ? DW'(1) :
                      (int'(cfg_val) > MAX_COLS ? DW'(MAX_COLS) : cfg_val);
    assign cfg_rows = (cfg_val == '0) ? DW'(1) :
                      (int'(cfg_val) > MAX_ROWS ? DW'(MAX_ROWS) : cfg_val);

    assign c_in = DW'(col);
    assign r_in = DW'(row);
    assign w_in = DW'(rect_width);
    assign h_in = DW'(rect_height);

    // raster walk over the current rectangle
    assign scan_last = (cx_reg + DW'(1) >= ex_reg) && (cy_reg + DW'(1) >= ey_reg);
    assign adv_x     = (cx_reg + DW'(1) < ex_reg) ? cx_reg + DW'(1) : bx_reg;
    assign adv_y     = (cx_reg + DW'(1) < ex_reg) ? cy_reg : cy_reg + DW'(1);

    assign area      = 10'(w_reg) * 10'(h_reg);
    assign used_sum  = 11'(used_reg) + 11'(area);
    assign tag_legal = int'(tag_reg) <= MAX_TAGS;
    assign sw        = tag_legal ? DW'(s_rdata[9:5]) : '0;
    assign sh        = tag_legal ? DW'(s_rdata[4:0]) : '0;
    assign rm_area   = 10'(sw) * 10'(sh);
    assign end_x     = (bx_reg + sw > cols_reg) ? cols_reg : bx_reg + sw;
    assign end_y     = (by_reg + sh > rows_reg) ? rows_reg : by_reg + sh;

    // next fit candidate
    assign nbx = (bx_reg + DW'(1) + DW'(w_reg) <= cols_reg) ? bx_reg + DW'(1) : '0;
    assign nby = (bx_reg + DW'(1) + DW'(w_reg) <= cols_reg) ? by_reg : by_reg + DW'(1);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        clr_next       = clr_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        tag_next       = tag_reg;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        used_next      = used_reg;
        res_ok_next    = res_ok_reg;
        res_tag_next   = res_tag_reg;
        ok_next        = ok_reg;
        tag_out_next   = tag_out_reg;
        used_out_next  = used_out_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (wr_cfg)
        begin
            if (paddr[2] == REG_COLS)
            begin
                cols_next = cfg_cols;
            end
            else
            begin
                rows_next = cfg_rows;
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    res_ok_next  = 1'b0;
                    res_tag_next = 8'd0;
                    w_next       = rect_width;
                    h_next       = rect_height;
                    tag_next     = owner_tag;
                    state_next   = ST_DONE;
                    case (cmd)
                        CMD_PLACE:
                        begin
                            if (owner_tag != 8'd0 && int'(owner_tag) <= MAX_TAGS &&
                                rect_width != 5'd0 && rect_height != 5'd0 &&
                                c_in + w_in <= cols_reg && r_in + h_in <= rows_reg)
                            begin
                                phase_next = PH_PLACE;
                                bx_next    = c_in;
                                by_next    = r_in;
                                cx_next    = c_in;
                                cy_next    = r_in;
                                ex_next    = c_in + w_in;
                                ey_next    = r_in + h_in;
                                state_next = ST_RD;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            if (c_in < cols_reg && r_in < rows_reg)
                            begin
                                phase_next = PH_LOOKUP;
                                cx_next    = c_in;
                                cy_next    = r_in;
                                state_next = ST_RD;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (c_in < cols_reg && r_in < rows_reg)
                            begin
                                phase_next = PH_RMCELL;
                                cx_next    = c_in;
                                cy_next    = r_in;
                                bx_next    = '0;
                                by_next    = '0;
                                ex_next    = c_in + DW'(1);
                                ey_next    = r_in + DW'(1);
                                state_next = ST_RD;
                            end
                        end
                        CMD_FIT:
                        begin
                            if (rect_width != 5'd0 && rect_height != 5'd0 &&
                                w_in <= cols_reg && h_in <= rows_reg)
                            begin
                                phase_next = PH_FIT;
                                bx_next    = '0;
                                by_next    = '0;
                                cx_next    = '0;
                                cy_next    = '0;
                                ex_next    = w_in;
                                ey_next    = h_in;
                                state_next = ST_RD;
                            end
                        end
                        CMD_CONTAINS:
                        begin
                            phase_next = PH_CONT;
                            bx_next    = '0;
                            by_next    = '0;
                            cx_next    = '0;
                            cy_next    = '0;
                            ex_next    = cols_reg;
                            ey_next    = rows_reg;
                            state_next = ST_RD;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                state_next = ST_RD;
                cx_next    = adv_x;
                cy_next    = adv_y;
                case (phase_reg)
                    PH_PLACE:
                    begin
                        if (g_rdata != 8'd0)
                        begin
                            state_next = ST_DONE;
                        end
                        else if (scan_last)
                        begin
                            cx_next    = bx_reg;
                            cy_next    = by_reg;
                            state_next = ST_WR;
                        end
                    end
                    PH_LOOKUP:
                    begin
                        res_tag_next = g_rdata;
                        res_ok_next  = g_rdata != 8'd0;
                        state_next   = ST_DONE;
                    end
                    PH_RMCELL:
                    begin
                        if (g_rdata == 8'd0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            tag_next   = g_rdata;
                            phase_next = PH_RMFIND;
                            cx_next    = '0;
                            cy_next    = '0;
                        end
                    end
                    PH_RMFIND:
                    begin
                        // the clicked cell itself always matches
                        if (g_rdata == tag_reg || scan_last)
                        begin
                            bx_next    = cx_reg;
                            by_next    = cy_reg;
                            state_next = ST_TSZ_RD;
                        end
                    end
                    PH_FIT:
                    begin
                        if (g_rdata != 8'd0)
                        begin
                            if (nby + DW'(h_reg) > rows_reg)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                bx_next = nbx;
                                by_next = nby;
                                cx_next = nbx;
                                cy_next = nby;
                                ex_next = nbx + DW'(w_reg);
                                ey_next = nby + DW'(h_reg);
                            end
                        end
                        else if (scan_last)
                        begin
                            res_ok_next = 1'b1;
                            state_next  = ST_DONE;
                        end
                    end
                    PH_CONT:
                    begin
                        if (g_rdata == tag_reg)
                        begin
                            res_ok_next = 1'b1;
                            state_next  = ST_DONE;
                        end
                        else if (scan_last)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_WR:
            begin
                cx_next = adv_x;
                cy_next = adv_y;
                if (scan_last)
                begin
                    res_ok_next = 1'b1;
                    state_next  = ST_DONE;
                    if (phase_reg == PH_PLACE)
                    begin
                        used_next = (used_sum > 11'(USED_MAX)) ? USED_MAX : used_sum[8:0];
                    end
                end
            end
            ST_TSZ_RD:
            begin
                state_next = ST_TSZ_USE;
            end
            ST_TSZ_USE:
            begin
                res_ok_next = 1'b1;
                used_next   = (10'(used_reg) > rm_area) ?
                              9'(10'(used_reg) - rm_area) : 9'd0;
                cx_next     = bx_reg;
                cy_next     = by_reg;
                ex_next     = end_x;
                ey_next     = end_y;
                state_next  = (sw == '0 || sh == '0) ? ST_DONE : ST_WR;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    ok_next        = res_ok_reg;
                    tag_out_next   = res_tag_reg;
                    used_out_next  = used_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= PH_PLACE;
            clr_reg       <= '0;
            cols_reg      <= DW'(COLS_RESET > MAX_COLS ? MAX_COLS : COLS_RESET);
            rows_reg      <= DW'(ROWS_RESET > MAX_ROWS ? MAX_ROWS : ROWS_RESET);
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            clr_reg       <= clr_next;
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        bx_reg       <= bx_next;
        by_reg       <= by_next;
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        tag_reg      <= tag_next;
        res_ok_reg   <= res_ok_next;
        res_tag_reg  <= res_tag_next;
        ok_reg       <= ok_next;
        tag_out_reg  <= tag_out_next;
        used_out_reg <= used_out_next;
    end

endmodule

@@ hdl/gra_ram.sv @@
module gra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sim/tb_grid_rectangle_allocator.sv @@
`timescale 1ns / 100ps

module tb_grid_rectangle_allocator;
    import gra_pkg::*;

    localparam int NCOL = DEF_MAX_COLS;
    localparam int NROW = DEF_MAX_ROWS;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    logic [2:0]  cmd = '0;
    logic [3:0]  col = '0;
    logic [3:0]  row = '0;
    logic [4:0]  rect_width = 5'd1;
    logic [4:0]  rect_height = 5'd1;
    logic [7:0]  owner_tag = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic        ok;
    logic [7:0]  tag_out;
    logic [8:0]  used_cells;

    grid_rectangle_allocator dut (.*);

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    typedef struct packed
    {
        logic       ok;
        logic [7:0] tag;
        logic [8:0] used;
    } alloc_result_t;

    // predicted state of the grid
    logic [7:0]    grid_tag [NROW*NCOL];
    logic [4:0]    size_w [256];
    logic [4:0]    size_h [256];
    int unsigned   used_total;
    int unsigned   cols_in_use;
    int unsigned   rows_in_use;
    alloc_result_t pending_results [$];
    int            mismatches = 0;
    bit            rsp_idle_on = 1'b1;
    bit            cmd_idle_on = 1'b1;
    bit            hold_rsp = 1'b0;

    function automatic int unsigned clamp_dim(logic [31:0] v, int unsigned hi);
        logic [4:0] x;
        x = v[4:0];
        if (x < 1) return 1;
        if (x > hi) return hi;
        return x;
    endfunction

    function automatic bit area_free(int unsigned c, int unsigned r,
                                     int unsigned w, int unsigned h);
        for (int dy = 0; dy < h; dy++)
            for (int dx = 0; dx < w; dx++)
                if (grid_tag[(r+dy)*NCOL + c+dx] != 0) return 1'b0;
        return 1'b1;
    endfunction

    // computes the result of one command and updates the predicted grid
    function automatic alloc_result_t predict_alloc(logic [2:0] op, int unsigned c,
        int unsigned r, int unsigned w, int unsigned h, logic [7:0] t);
        alloc_result_t res;
        logic [7:0] owner;
        int unsigned ac, ar, area;
        bit found;
        res = '0;
        case (op)
            CMD_PLACE:
            begin
                if (t != 0 && t <= DEF_MAX_TAGS && w != 0 && h != 0 &&
                    c + w <= cols_in_use && r + h <= rows_in_use && area_free(c, r, w, h))
                begin
                    for (int dy = 0; dy < h; dy++)
                        for (int dx = 0; dx < w; dx++)
                            grid_tag[(r+dy)*NCOL + c+dx] = t;
                    size_w[t] = 5'(w);
                    size_h[t] = 5'(h);
                    used_total += w * h;
                    if (used_total > 256) used_total = 256;
                    res.ok = 1'b1;
                end
            end
            CMD_LOOKUP:
            begin
                if (c < cols_in_use && r < rows_in_use)
                begin
                    res.tag = grid_tag[r*NCOL + c];
                    res.ok = res.tag != 0;
                end
            end
            CMD_REMOVE:
            begin
                if (c < cols_in_use && r < rows_in_use && grid_tag[r*NCOL + c] != 0)
                begin
                    owner = grid_tag[r*NCOL + c];
                    ac = c;
                    ar = r;
                    found = 1'b0;
                    for (int dy = 0; dy <= r && !found; dy++)
                        for (int dx = 0; dx <= c && !found; dx++)
                            if (grid_tag[dy*NCOL + dx] == owner)
                            begin
                                ac = dx;
                                ar = dy;
                                found = 1'b1;
                            end
                    for (int dy = 0; dy < size_h[owner]; dy++)
                        for (int dx = 0; dx < size_w[owner]; dx++)
                            if (ar + dy < rows_in_use && ac + dx < cols_in_use)
                                grid_tag[(ar+dy)*NCOL + ac+dx] = 8'd0;
                    area = size_w[owner] * size_h[owner];
                    used_total = (used_total > area) ? used_total - area : 0;
                    res.ok = 1'b1;
                end
            end
            CMD_FIT:
            begin
                if (w != 0 && h != 0 && w <= cols_in_use && h <= rows_in_use)
                    for (int py = 0; py + h <= rows_in_use && !res.ok; py++)
                        for (int px = 0; px + w <= cols_in_use && !res.ok; px++)
                            if (area_free(px, py, w, h)) res.ok = 1'b1;
            end
            CMD_CONTAINS:
            begin
                for (int dy = 0; dy < rows_in_use && !res.ok; dy++)
                    for (int dx = 0; dx < cols_in_use && !res.ok; dx++)
                        if (grid_tag[dy*NCOL + dx] == t) res.ok = 1'b1;
            end
            default: ;
        endcase
        res.used = used_total[8:0];
        return res;
    endfunction

    // one item through the command channel, with optional idle burst first
    task automatic send_item(logic [2:0] op, logic [3:0] c, logic [3:0] r,
                             logic [4:0] w, logic [4:0] h, logic [7:0] t);
        if (cmd_idle_on && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd_valid   <= 1'b1;
        cmd         <= op;
        col         <= c;
        row         <= r;
        rect_width  <= w;
        rect_height <= h;
        owner_tag   <= t;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        // accepted at this edge
        pending_results.push_back(predict_alloc(op, c, r, w, h, t));
    endtask

    // wait for every outstanding result, then let the block settle
    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(int idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_COLS) cols_in_use = clamp_dim(value, DEF_MAX_COLS);
        else rows_in_use = clamp_dim(value, DEF_MAX_ROWS);
    endtask

    task automatic set_grid(logic [31:0] c, logic [31:0] r);
        drain_results();
        write_reg(REG_COLS, c);
        write_reg(REG_ROWS, r);
    endtask

    // result checker, taking a result whenever the receiver does not stall
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result ok=%0b tag=%0d used=%0d",
                                               ok, tag_out, used_cells);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.ok !== ok || want.tag !== tag_out || want.used !== used_cells)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected ok=%0b tag=%0d used=%0d, got ok=%0b tag=%0d used=%0d",
                                 want.ok, want.tag, want.used, ok, tag_out, used_cells);
                end
            end
        end
    end

    // receiver stall: random bursts, or a long hold-off when asked
    initial
    begin
        forever
        begin
            if (hold_rsp)
            begin
                rsp_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                hold_rsp = 1'b0;
                rsp_stall <= 1'b0;
            end
            else if (rsp_idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            @(posedge clk);
        end
    end

    // edge cases of each command on the reset grid
    task automatic test_directed();
        send_item(CMD_CONTAINS, 0, 0, 1, 1, 8'd0);
        send_item(CMD_PLACE, 0, 0, 3, 2, 8'd7);
        send_item(CMD_PLACE, 1, 1, 1, 1, 8'd9);
        send_item(CMD_PLACE, 9, 3, 1, 1, 8'd255);
        send_item(CMD_PLACE, 9, 3, 2, 1, 8'd5);
        send_item(CMD_PLACE, 4, 0, 0, 1, 8'd5);
        send_item(CMD_PLACE, 4, 0, 1, 0, 8'd5);
        send_item(CMD_PLACE, 4, 0, 1, 1, 8'd0);
        send_item(CMD_PLACE, 15, 15, 31, 31, 8'd6);
        send_item(CMD_LOOKUP, 2, 1, 0, 0, 8'd0);
        send_item(CMD_LOOKUP, 15, 15, 0, 0, 8'd0);
        send_item(CMD_LOOKUP, 5, 2, 0, 0, 8'd0);
        send_item(CMD_CONTAINS, 0, 0, 0, 0, 8'd7);
        send_item(CMD_CONTAINS, 0, 0, 0, 0, 8'd8);
        send_item(CMD_FIT, 0, 0, 10, 2, 8'd0);
        send_item(CMD_FIT, 0, 0, 11, 1, 8'd0);
        send_item(CMD_FIT, 0, 0, 0, 1, 8'd0);
        send_item(CMD_FIT, 0, 0, 7, 4, 8'd0);
        send_item(CMD_REMOVE, 2, 1, 0, 0, 8'd0);
        send_item(CMD_REMOVE, 2, 1, 0, 0, 8'd0);
        send_item(CMD_REMOVE, 15, 0, 0, 0, 8'd0);
        send_item(CMD_REMOVE, 9, 3, 0, 0, 8'd0);
        send_item(3'd5, 0, 0, 1, 1, 8'd1);
        send_item(3'd7, 15, 15, 31, 31, 8'd255);
        send_item(CMD_FIT, 0, 0, 10, 4, 8'd0);
    endtask

    // mostly places and removes on small shapes, with queries mixed in
    task automatic random_item(int unsigned cmax, int unsigned rmax);
        int unsigned k;
        logic [2:0] op;
        k = $urandom_range(0, 99);
        if (k < 35) op = CMD_PLACE;
        else if (k < 55) op = CMD_REMOVE;
        else if (k < 70) op = CMD_LOOKUP;
        else if (k < 82) op = CMD_FIT;
        else if (k < 95) op = CMD_CONTAINS;
        else op = 3'($urandom_range(5, 7));
        if (k % 10 == 0)
            send_item(op, 4'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                      8'($urandom));
        else
            send_item(op, 4'($urandom_range(0, cmax - 1)), 4'($urandom_range(0, rmax - 1)),
                      5'($urandom_range(1, 4)), 5'($urandom_range(1, 3)),
                      8'($urandom_range(0, 24)));
    endtask

    task automatic test_random(int n, int unsigned cmax, int unsigned rmax);
        for (int i = 0; i < n; i++) random_item(cmax, rmax);
    endtask

    // long receiver hold-off while commands keep coming
    task automatic test_backpressure();
        hold_rsp = 1'b1;
        test_random(30, cols_in_use, rows_in_use);
    endtask

    initial
    begin
        for (int i = 0; i < NROW*NCOL; i++) grid_tag[i] = 8'd0;
        for (int i = 0; i < 256; i++)
        begin
            size_w[i] = 5'd0;
            size_h[i] = 5'd0;
        end
        used_total  = 0;
        cols_in_use = COLS_RESET;
        rows_in_use = ROWS_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_grid(32'd16, 32'd16);
        test_random(200, 16, 16);
        test_backpressure();
        set_grid(32'd0, 32'd31);
        test_random(60, 1, 16);
        set_grid(32'd17, 32'd1);
        test_random(60, 16, 1);
        set_grid(32'd6, 32'd5);
        test_random(150, 6, 5);
        set_grid(32'hFFFF_FFE3, 32'd12);
        test_random(60, 3, 12);
        set_grid(32'd16, 32'd16);
        // final stretch without idling
        cmd_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        test_random(150, 16, 16);

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS grid_rectangle_allocator");
        else
            $display("FAIL grid_rectangle_allocator");
        $finish;
    end

    // run limit, well above every item taking its longest fit scan
    initial
    begin
        #400000000;
        $display("FAIL grid_rectangle_allocator");
        $finish;
    end

endmodule
